/* src/morp_pkg.sv */
`timescale 1ns / 1ps

package morp_pkg;

    localparam int MAX_POINTS = 4096;
    localparam int IDX_W      = 12;
    localparam int CNT_W      = 13;
    localparam int COORD_W    = 24;
    localparam int EXT_W      = 23;
    localparam int GRID_W     = 11;
    localparam int CELL_W     = 10;
    localparam int CODE_W     = 30;
    localparam int KEY_W      = CODE_W + IDX_W;
    localparam int NUM_W      = COORD_W + GRID_W;
    localparam int BIT_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int GRID_MAX   = 1024;

    // Input operation codes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CUBE_MIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUBE_EXTENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE   = 2'd2;

    // Source of the coordinates in a result
    localparam logic [1:0] SRC_ZERO = 2'd0;
    localparam logic [1:0] SRC_IN   = 2'd1;
    localparam logic [1:0] SRC_MEM  = 2'd2;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL   = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_CODE  = 7'b0001000,
        ST_SCAN  = 7'b0010000,
        ST_FETCH = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    // Interleave three cell numbers: y to bit 3k, x to 3k+1, z to 3k+2
    function automatic logic [CODE_W-1:0] interleave(
        input logic [CELL_W-1:0] cx,
        input logic [CELL_W-1:0] cy,
        input logic [CELL_W-1:0] cz
    );
        logic [CODE_W-1:0] r;
        r = '0;
        for (int k = 0; k < CELL_W; k++)
        begin
            r[3*k]     = cy[k];
            r[3*k + 1] = cx[k];
            r[3*k + 2] = cz[k];
        end
        return r;
    endfunction

endpackage

/* src/morton_order_points_unit.sv */
`timescale 1ns / 1ps

// Morton-order point store. A load (tuser 0) quantises x, y and z against the
// cube registers with one shared restoring divider (a set-up step per axis,
// then 35 quotient bits, one quotient bit a cycle), then, unless the store is
// full, scans the stored codes once to count distinct codes. A read (tuser 1)
// scans the code memory for the next point in (code, load index) order and
// fetches it from the point memory, or returns the empty status when no point
// is left. Clear and the spare code go straight to the result. Both memories
// have one read port, and the scan through the code memory sets the cost of
// loads and reads. The next transaction is taken while a result still waits
// on the master side.
module morton_order_points_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // point_x, point_y, point_z
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [127:0] m_tdata,  // out_x, out_y, out_z, morton_code,
                                   // original_index, distinct_codes, zero pad
    output logic [1:0]  m_tuser,   // status
    output logic        m_tlast,   // last_in_order
    input  logic        cfg_wen,
    input  logic [morp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [morp_pkg::COORD_W-1:0]   cfg_data
);
    import morp_pkg::*;

    // Configuration
    logic signed [COORD_W-1:0] cube_min_reg;
    logic [EXT_W-1:0]          cube_ext_reg;
    logic [GRID_W-1:0]         grid_reg;

    // Control
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rpos_reg, rpos_next;
    logic [CNT_W-1:0]  distinct_reg, distinct_next;
    logic [CNT_W-1:0]  addr_reg, addr_next;
    logic              pend_reg, pend_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // Datapath
    logic [1:0]                op_reg, op_next;
    logic signed [COORD_W-1:0] px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic [1:0]                axis_reg, axis_next;
    logic [NUM_W-1:0]          num_reg, num_next;
    logic [COORD_W-1:0]        rem_reg, rem_next;
    logic [BIT_W-1:0]          bit_reg, bit_next;
    logic [CELL_W-1:0]         cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [CODE_W-1:0]         code_reg, code_next;
    logic [KEY_W-1:0]          prev_key_reg, prev_key_next;
    logic [KEY_W-1:0]          best_key_reg, best_key_next;
    logic                      best_valid_reg, best_valid_next;
    logic                      seen_reg, seen_next;
    logic [IDX_W-1:0]          pend_idx_reg, pend_idx_next;
    logic [1:0]                res_status_reg, res_status_next;
    logic [1:0]                res_src_reg, res_src_next;
    logic [CODE_W-1:0]         res_code_reg, res_code_next;
    logic [IDX_W-1:0]          res_idx_reg, res_idx_next;
    logic                      res_last_reg, res_last_next;
    logic [CNT_W-1:0]          res_distinct_reg, res_distinct_next;
    logic [127:0]              m_tdata_reg, m_tdata_next;
    logic [1:0]                m_tuser_reg, m_tuser_next;
    logic                      m_tlast_reg, m_tlast_next;

    // Memories
    logic [3*COORD_W-1:0] point_mem [MAX_POINTS];
    logic [CODE_W-1:0]    code_mem  [MAX_POINTS];
    logic [CODE_W-1:0]    code_q;
    logic [3*COORD_W-1:0] point_q;
    logic                 mem_we;
    logic [IDX_W-1:0]     code_raddr;
    logic [IDX_W-1:0]     point_raddr;

    // Effective grid and extent
    logic [GRID_W-1:0]        g_eff;
    logic [GRID_W-1:0]        g_m1;
    logic [EXT_W-1:0]         ext_eff;
    logic signed [COORD_W:0]  diff;
    logic signed [COORD_W-1:0] coord_sel;
    logic [COORD_W-1:0]       trial;
    logic                     q_bit;
    logic [NUM_W-1:0]         quot;
    logic [CELL_W-1:0]        cell_val;
    logic [KEY_W-1:0]         cand_key;
    logic                     accept_in;
    logic                     out_free;
    logic [COORD_W-1:0]       rx, ry, rz;

    assign g_eff   = (grid_reg == '0) ? GRID_W'(1)
                   : (grid_reg > GRID_W'(GRID_MAX)) ? GRID_W'(GRID_MAX) : grid_reg;
    assign g_m1    = g_eff - GRID_W'(1);
    assign ext_eff = (cube_ext_reg == '0) ? EXT_W'(1) : cube_ext_reg;

    assign coord_sel = (axis_reg == 2'd0) ? px_reg : (axis_reg == 2'd1) ? py_reg : pz_reg;
    assign diff      = {coord_sel[COORD_W-1], coord_sel}
                     - {cube_min_reg[COORD_W-1], cube_min_reg};

    // One restoring division step
    assign trial = {rem_reg[COORD_W-2:0], num_reg[NUM_W-1]};
    assign q_bit = (trial >= {1'b0, ext_eff});
    assign quot  = {num_reg[NUM_W-2:0], q_bit};
    assign cell_val = (quot > NUM_W'(g_m1)) ? g_m1[CELL_W-1:0] : quot[CELL_W-1:0];

    assign cand_key  = {code_q, pend_idx_reg};
    assign accept_in = s_tvalid && (state_reg == ST_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign code_raddr  = addr_reg[IDX_W-1:0];
    assign point_raddr = best_key_reg[IDX_W-1:0];
    assign mem_we      = (state_reg == ST_SCAN) && (op_reg == OP_LOAD)
                       && (addr_reg == count_reg) && !pend_reg;

    // Result coordinates by source
    always_comb
    begin
        case (res_src_reg)
            SRC_IN:
            begin
                rx = px_reg;
                ry = py_reg;
                rz = pz_reg;
            end
            SRC_MEM:
            begin
                rx = point_q[COORD_W-1:0];
                ry = point_q[2*COORD_W-1:COORD_W];
                rz = point_q[3*COORD_W-1:2*COORD_W];
            end
            default:
            begin
                rx = '0;
                ry = '0;
                rz = '0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        rpos_next         = rpos_reg;
        distinct_next     = distinct_reg;
        addr_next         = addr_reg;
        pend_next         = 1'b0;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        op_next           = op_reg;
        px_next           = px_reg;
        py_next           = py_reg;
        pz_next           = pz_reg;
        axis_next         = axis_reg;
        num_next          = num_reg;
        rem_next          = rem_reg;
        bit_next          = bit_reg;
        cx_next           = cx_reg;
        cy_next           = cy_reg;
        cz_next           = cz_reg;
        code_next         = code_reg;
        prev_key_next     = prev_key_reg;
        best_key_next     = best_key_reg;
        best_valid_next   = best_valid_reg;
        seen_next         = seen_reg;
        pend_idx_next     = addr_reg[IDX_W-1:0];
        res_status_next   = res_status_reg;
        res_src_next      = res_src_reg;
        res_code_next     = res_code_reg;
        res_idx_next      = res_idx_reg;
        res_last_next     = res_last_reg;
        res_distinct_next = res_distinct_reg;
        m_tdata_next      = m_tdata_reg;
        m_tuser_next      = m_tuser_reg;
        m_tlast_next      = m_tlast_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    op_next           = s_tuser;
                    px_next           = s_tdata[COORD_W-1:0];
                    py_next           = s_tdata[2*COORD_W-1:COORD_W];
                    pz_next           = s_tdata[3*COORD_W-1:2*COORD_W];
                    res_status_next   = STAT_OK;
                    res_src_next      = SRC_ZERO;
                    res_code_next     = '0;
                    res_idx_next      = '0;
                    res_last_next     = 1'b0;
                    res_distinct_next = distinct_reg;
                    addr_next         = '0;
                    seen_next         = 1'b0;
                    best_valid_next   = 1'b0;
                    axis_next         = 2'd0;
                    case (s_tuser)
                        OP_LOAD:
                        begin
                            state_next = ST_MUL;
                        end
                        OP_READ:
                        begin
                            if (rpos_reg >= count_reg)
                            begin
                                res_status_next = STAT_EMPTY;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next        = '0;
                            rpos_next         = '0;
                            distinct_next     = '0;
                            res_distinct_next = '0;
                            state_next        = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // Form the scaled offset for the current axis; a non-positive offset gives cell 0
            ST_MUL:
            begin
                rem_next = '0;
                bit_next = '0;
                num_next = diff[COORD_W-1:0] * g_eff;
                if (diff <= 0)
                begin
                    case (axis_reg)
                        2'd0:    cx_next = '0;
                        2'd1:    cy_next = '0;
                        default: cz_next = '0;
                    endcase
                    if (axis_reg == 2'd2)
                        state_next = ST_CODE;
                    else
                        axis_next = axis_reg + 2'd1;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end

            // One quotient bit per cycle, clamp at the end
            ST_DIV:
            begin
                num_next = quot;
                rem_next = q_bit ? (trial - {1'b0, ext_eff}) : trial;
                bit_next = bit_reg + BIT_W'(1);
                if (bit_reg == BIT_W'(NUM_W - 1))
                begin
                    case (axis_reg)
                        2'd0:    cx_next = cell_val;
                        2'd1:    cy_next = cell_val;
                        default: cz_next = cell_val;
                    endcase
                    if (axis_reg == 2'd2)
                    begin
                        state_next = ST_CODE;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_MUL;
                    end
                end
            end

            ST_CODE:
            begin
                code_next     = interleave(cx_reg, cy_reg, cz_reg);
                res_code_next = interleave(cx_reg, cy_reg, cz_reg);
                res_src_next  = SRC_IN;
                if (count_reg >= CNT_W'(MAX_POINTS))
                begin
                    res_status_next = STAT_FULL;
                    state_next      = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end

            // Walk the code memory; compare in the cycle after each address is issued
            ST_SCAN:
            begin
                if (addr_reg < count_reg)
                begin
                    addr_next = addr_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    if (op_reg == OP_LOAD)
                    begin
                        if (code_q == code_reg)
                            seen_next = 1'b1;
                    end
                    else if (((rpos_reg == '0) || (cand_key > prev_key_reg))
                             && (!best_valid_reg || (cand_key < best_key_reg)))
                    begin
                        best_key_next   = cand_key;
                        best_valid_next = 1'b1;
                    end
                end
                if ((addr_reg == count_reg) && !pend_reg)
                begin
                    if (op_reg == OP_LOAD)
                    begin
                        res_idx_next      = count_reg[IDX_W-1:0];
                        res_distinct_next = distinct_reg + CNT_W'(!seen_reg);
                        distinct_next     = distinct_reg + CNT_W'(!seen_reg);
                        count_next        = count_reg + CNT_W'(1);
                        rpos_next         = '0;
                        state_next        = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end

            // Point memory read of the chosen entry
            ST_FETCH:
            begin
                res_src_next  = SRC_MEM;
                res_code_next = best_key_reg[KEY_W-1:IDX_W];
                res_idx_next  = best_key_reg[IDX_W-1:0];
                res_last_next = (rpos_reg + CNT_W'(1) == count_reg);
                prev_key_next = best_key_reg;
                rpos_next     = rpos_reg + CNT_W'(1);
                state_next    = ST_DONE;
            end

            // Hand the result to the output register
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, res_distinct_reg, res_idx_reg, res_code_reg,
                                     rz, ry, rx};
                    m_tuser_next  = res_status_reg;
                    m_tlast_next  = res_last_reg;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            rpos_reg     <= '0;
            distinct_reg <= '0;
            addr_reg     <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            cube_min_reg <= -24'sd1048576;
            cube_ext_reg <= EXT_W'(2097152);
            grid_reg     <= GRID_W'(GRID_MAX);
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rpos_reg     <= rpos_next;
            distinct_reg <= distinct_next;
            addr_reg     <= addr_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wen)
            begin
                case (cfg_index)
                    CFG_CUBE_MIN:    cube_min_reg <= cfg_data;
                    CFG_CUBE_EXTENT: cube_ext_reg <= cfg_data[EXT_W-1:0];
                    CFG_GRID_SIZE:   grid_reg     <= cfg_data[GRID_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        px_reg           <= px_next;
        py_reg           <= py_next;
        pz_reg           <= pz_next;
        axis_reg         <= axis_next;
        num_reg          <= num_next;
        rem_reg          <= rem_next;
        bit_reg          <= bit_next;
        cx_reg           <= cx_next;
        cy_reg           <= cy_next;
        cz_reg           <= cz_next;
        code_reg         <= code_next;
        prev_key_reg     <= prev_key_next;
        best_key_reg     <= best_key_next;
        best_valid_reg   <= best_valid_next;
        seen_reg         <= seen_next;
        pend_idx_reg     <= pend_idx_next;
        res_status_reg   <= res_status_next;
        res_src_reg      <= res_src_next;
        res_code_reg     <= res_code_next;
        res_idx_reg      <= res_idx_next;
        res_last_reg     <= res_last_next;
        res_distinct_reg <= res_distinct_next;
        m_tdata_reg      <= m_tdata_next;
        m_tuser_reg      <= m_tuser_next;
        m_tlast_reg      <= m_tlast_next;
    end

    // Code memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            code_mem[count_reg[IDX_W-1:0]] <= code_reg;
        code_q <= code_mem[code_raddr];
    end

    // Point memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            point_mem[count_reg[IDX_W-1:0]] <= {pz_reg, py_reg, px_reg};
        if (state_reg == ST_FETCH)
            point_q <= point_mem[point_raddr];
    end

endmodule
